### hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants of the block pool allocator
// Item field widths, result codes, operation codes and controller commands.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // item field widths
  localparam int FUNC_W     = 1;
  localparam int SIZE_W     = 10;
  localparam int IN_IDX_W   = 7;
  localparam int STATUS_W   = 2;
  localparam int GRANT_W    = 7;
  localparam int BLK_OUT_W  = 8;
  localparam int BYTE_OUT_W = 16;
  localparam int CFG_W      = 9;
  localparam int HELD_W     = 9;

  // packed stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // largest size one block may ever satisfy, and the register reset value
  localparam int                MAX_BLOCK_BYTES   = 256;
  localparam logic [CFG_W-1:0]  RESET_BLOCK_BYTES = 9'd256;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_TOO_LARGE     = 2'd1,
    ST_NO_BLOCK      = 2'd2,
    ST_NOT_ALLOCATED = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // item accepted: capture it and read its block word
    logic commit;  // apply the operation and load the result register
  } cmd_t;

endpackage

### hw/rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl: sequencer of the block pool allocator
// Two-state machine: takes an item, then commits it once the result
// register is free. Owns the stream handshakes.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output fbpa_pkg::cmd_t cmd
);
  import fbpa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  // command decode
  assign in_tready  = (state_r == S_IDLE);
  assign commit     = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.commit = commit;
  assign out_tvalid = out_valid_r;

  // next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted item blocks the input until it is committed
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready)
    else $error("input ready while an item is in flight");

  // a new result appears only from a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(commit))
    else $error("result valid without a commit");

  // a commit never overwrites a result that is not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule

### hw/rtl/fbpa_datapath.sv
// ----------------------------------------------------------------------------
// fbpa_datapath: block memory, free list registers and counters
// One word per block holds its in-use mark, held size and free-list link.
// A fill count stands for the reset chain: blocks at or above it are fresh.
// ----------------------------------------------------------------------------
module fbpa_datapath #(
  parameter int NUM_BLOCKS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fbpa_pkg::cmd_t                    cmd,
  input  logic [fbpa_pkg::FUNC_W-1:0]       item_func,
  input  logic [fbpa_pkg::SIZE_W-1:0]       item_size,
  input  logic [fbpa_pkg::IN_IDX_W-1:0]     item_index,
  input  logic                              cfg_wr_en,
  input  logic [fbpa_pkg::CFG_W-1:0]        cfg_wr_data,
  output logic [fbpa_pkg::STATUS_W-1:0]     res_status,
  output logic [fbpa_pkg::GRANT_W-1:0]      res_granted,
  output logic [fbpa_pkg::BLK_OUT_W-1:0]    res_blocks,
  output logic [fbpa_pkg::BYTE_OUT_W-1:0]   res_bytes
);
  import fbpa_pkg::*;

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int BYTE_W = IDX_W + HELD_W;

  typedef struct packed {
    logic              in_use;
    logic [HELD_W-1:0] held;
    logic [IDX_W-1:0]  link;
  } word_t;

  // block memory
  word_t mem [NUM_BLOCKS];
  word_t rd_word_r;

  // pool state
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic              empty_r, empty_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CFG_W-1:0]  block_bytes_r;

  // captured item
  logic [FUNC_W-1:0] func_r;
  logic [SIZE_W-1:0] size_r;
  logic [IDX_W-1:0]  addr_r;
  logic              in_range_r;

  // result register
  status_t               status_r, status_nxt;
  logic [GRANT_W-1:0]    granted_r, granted_nxt;
  logic [BLK_OUT_W-1:0]  blocks_out_r;
  logic [BYTE_OUT_W-1:0] bytes_out_r;

  logic [31:0]       index32;
  logic              index_ok;
  logic [IDX_W-1:0]  rd_addr;
  logic [CFG_W-1:0]  size_lim;
  logic              entry_valid;
  logic [IDX_W-1:0]  fresh_link;
  logic [IDX_W-1:0]  cur_link;
  logic              mem_we;
  word_t             wr_word;

  // read address: head for allocate, returned block for free
  assign index32  = 32'(item_index);
  assign index_ok = (index32 < 32'(NUM_BLOCKS));
  assign rd_addr  = (item_func == FUNC_FREE) ? index32[IDX_W-1:0] : head_r;

  // effective size limit
  assign size_lim = (32'(block_bytes_r) > 32'(MAX_BLOCK_BYTES)) ?
                    CFG_W'(MAX_BLOCK_BYTES) : block_bytes_r;

  // entries below the fill count hold written words; the rest are fresh
  assign entry_valid = ({1'b0, addr_r} < fill_r);
  assign fresh_link  = (32'(addr_r) == 32'(NUM_BLOCKS - 1)) ? '0 : addr_r + 1'b1;
  assign cur_link    = entry_valid ? rd_word_r.link : fresh_link;

  // operation
  always_comb begin
    head_nxt    = head_r;
    empty_nxt   = empty_r;
    cnt_nxt     = cnt_r;
    bytes_nxt   = bytes_r;
    fill_nxt    = fill_r;
    status_nxt  = ST_OK;
    granted_nxt = '0;
    mem_we      = 1'b0;
    wr_word     = rd_word_r;
    if (func_r == FUNC_ALLOC) begin
      if (32'(size_r) > 32'(size_lim)) begin
        status_nxt = ST_TOO_LARGE;
      end else if (empty_r) begin
        status_nxt = ST_NO_BLOCK;
      end else begin
        granted_nxt = GRANT_W'(32'(addr_r));
        mem_we      = 1'b1;
        wr_word     = '{in_use: 1'b1, held: size_r[HELD_W-1:0], link: cur_link};
        head_nxt    = cur_link;
        cnt_nxt     = cnt_r + 1'b1;
        bytes_nxt   = bytes_r + BYTE_W'(size_r[HELD_W-1:0]);
        empty_nxt   = (32'(cnt_nxt) >= 32'(NUM_BLOCKS));
        if (!entry_valid) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
    end else begin
      if (!in_range_r || !entry_valid || !rd_word_r.in_use) begin
        status_nxt = ST_NOT_ALLOCATED;
      end else begin
        mem_we    = 1'b1;
        wr_word   = '{in_use: 1'b0, held: rd_word_r.held, link: head_r};
        head_nxt  = addr_r;
        empty_nxt = 1'b0;
        cnt_nxt   = cnt_r - 1'b1;
        bytes_nxt = bytes_r - BYTE_W'(rd_word_r.held);
      end
    end
  end

  // memory port: one read on accept, one write on a commit that changes its block
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_word_r <= mem[rd_addr];
    end
    if (cmd.commit && mem_we) begin
      mem[addr_r] <= wr_word;
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r     <= item_func;
      size_r     <= item_size;
      addr_r     <= rd_addr;
      in_range_r <= index_ok;
    end
    if (cmd.commit) begin
      status_r     <= status_nxt;
      granted_r    <= granted_nxt;
      blocks_out_r <= (32'(cnt_nxt) > 32'd255) ? 8'hFF : BLK_OUT_W'(32'(cnt_nxt));
      bytes_out_r  <= (32'(bytes_nxt) > 32'hFFFF) ? 16'hFFFF :
                      BYTE_OUT_W'(32'(bytes_nxt));
    end
  end

  // pool state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      empty_r       <= 1'b0;
      cnt_r         <= '0;
      bytes_r       <= '0;
      fill_r        <= '0;
      block_bytes_r <= RESET_BLOCK_BYTES;
    end else begin
      if (cfg_wr_en) begin
        block_bytes_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        head_r  <= head_nxt;
        empty_r <= empty_nxt;
        cnt_r   <= cnt_nxt;
        bytes_r <= bytes_nxt;
        fill_r  <= fill_nxt;
      end
    end
  end

  assign res_status  = status_r;
  assign res_granted = granted_r;
  assign res_blocks  = blocks_out_r;
  assign res_bytes   = bytes_out_r;

  // block count stays within the pool
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(NUM_BLOCKS))
    else $error("block count beyond pool size");

  // empty list means every block is in use
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (32'(cnt_r) == 32'(NUM_BLOCKS)))
    else $error("list empty with blocks free");

  // fill count only grows, never below the used count nor above the pool size
  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r >= cnt_r) && (32'(fill_r) <= 32'(NUM_BLOCKS)))
    else $error("fill count out of order");

endmodule

### hw/rtl/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core: fixed-size block pool with a LIFO free list
// Allocate takes the head block, free pushes a block back on the head.
// Every item gives one result with status and pool occupancy.
//
//   Channel  Direction  Carries
//   in_      slave      tuser: func; tdata: request_size, block_index
//   out_     master     tdata: status, granted_block, blocks_in_use,
//                              bytes_in_use
//   cfg_     write      block_bytes
//
// On accept in S_IDLE the block word is read from the
// block memory; S_EXEC then updates the pool and loads the result register.
// The item stays in S_EXEC while the result register holds a
// result not yet taken. No clearing pass after reset: a fill count marks
// the blocks never handed out, so items are taken from the first cycle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core #(
  parameter int NUM_BLOCKS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata bits: request_size [9:0], block_index [16:10], zero pad [23:17]
  input  logic [fbpa_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser bits: func [0]
  input  logic [fbpa_pkg::FUNC_W-1:0]       in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata bits: status [1:0], granted_block [8:2], blocks_in_use [16:9],
  //   bytes_in_use [32:17], zero pad [39:33]
  output logic [fbpa_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic [fbpa_pkg::CFG_W-1:0]        cfg_wr_data
);
  import fbpa_pkg::*;

  cmd_t                  cmd;
  logic [STATUS_W-1:0]   res_status;
  logic [GRANT_W-1:0]    res_granted;
  logic [BLK_OUT_W-1:0]  res_blocks;
  logic [BYTE_OUT_W-1:0] res_bytes;

  // sequencer
  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // pool datapath
  fbpa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .item_func   (in_tuser),
    .item_size   (in_tdata[SIZE_W-1:0]),
    .item_index  (in_tdata[SIZE_W +: IN_IDX_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_status  (res_status),
    .res_granted (res_granted),
    .res_blocks  (res_blocks),
    .res_bytes   (res_bytes)
  );

  // result packing, lowest field first
  assign out_tdata = {7'd0, res_bytes, res_blocks, res_granted, res_status};

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level check of the fixed block pool allocator
// A queue of allocate and free items feeds a clocked driver. A local model of
// the free list predicts each result when its item is accepted. A clocked
// monitor compares every result field with the oldest prediction. The run
// steps through several block size settings with random handshake gaps.
// ----------------------------------------------------------------------------
module testbench;
  import fbpa_pkg::*;

  localparam int NUM_BLK = 128;

  // out_tdata field offsets, lowest field first
  localparam int GRANT_LO = STATUS_W;
  localparam int BLK_LO   = GRANT_LO + GRANT_W;
  localparam int BYTE_LO  = BLK_LO + BLK_OUT_W;
  localparam int IN_PAD_W = IN_DATA_W - SIZE_W - IN_IDX_W;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [SIZE_W-1:0]   req_bytes;
    logic [IN_IDX_W-1:0] blk_idx;
  } pool_op_t;

  typedef struct {
    status_t               status;
    logic [GRANT_W-1:0]    grant;
    logic [BLK_OUT_W-1:0]  blocks;
    logic [BYTE_OUT_W-1:0] bytes;
  } pool_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [FUNC_W-1:0]     in_tuser    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;

  pool_op_t     pending_ops[$];
  pool_op_t     offered_op;
  pool_result_t expected_results[$];
  int           error_count  = 0;
  int           random_count = 0;
  int           tx_idle_pct  = 29;
  int           rx_idle_pct  = 56;
  logic         stall_req    = 1'b0;
  logic         stall_done;
  int           stall_left;

  // free list model
  logic [IN_IDX_W-1:0] free_link [NUM_BLK];
  logic [IN_IDX_W-1:0] free_head;
  logic                pool_full;
  logic                block_taken [NUM_BLK];
  logic [HELD_W-1:0]   taken_size [NUM_BLK];
  int unsigned         taken_blocks;
  int unsigned         taken_bytes;
  logic [CFG_W-1:0]    blk_bytes_cfg;

  fixed_block_pool_allocator_core #(.NUM_BLOCKS(NUM_BLK)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void reset_pool_model();
    for (int i = 0; i < NUM_BLK; i++) begin
      free_link[i]   = IN_IDX_W'((i + 1) % NUM_BLK);
      block_taken[i] = 1'b0;
      taken_size[i]  = '0;
    end
    free_head     = '0;
    pool_full     = 1'b0;
    taken_blocks  = 0;
    taken_bytes   = 0;
    blk_bytes_cfg = RESET_BLOCK_BYTES;
  endfunction

  // apply one operation to the free list model and return its result
  function automatic pool_result_t apply_pool_op(pool_op_t op);
    pool_result_t        res;
    int unsigned         limit;
    logic [IN_IDX_W-1:0] b;
    res.status = ST_OK;
    res.grant  = '0;
    limit = (blk_bytes_cfg > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : blk_bytes_cfg;
    if (op.func == FUNC_ALLOC) begin
      // size check wins over an empty list
      if (op.req_bytes > limit) begin
        res.status = ST_TOO_LARGE;
      end else if (pool_full) begin
        res.status = ST_NO_BLOCK;
      end else begin
        b              = free_head;
        res.grant      = b;
        block_taken[b] = 1'b1;
        taken_size[b]  = HELD_W'(op.req_bytes);
        taken_bytes   += op.req_bytes;
        taken_blocks  += 1;
        free_head      = free_link[b];
        pool_full      = (taken_blocks >= NUM_BLK);
      end
    end else begin
      if (!block_taken[op.blk_idx]) begin
        res.status = ST_NOT_ALLOCATED;
      end else begin
        block_taken[op.blk_idx] = 1'b0;
        free_link[op.blk_idx]   = free_head;
        free_head               = op.blk_idx;
        pool_full               = 1'b0;
        taken_bytes            -= taken_size[op.blk_idx];
        taken_blocks           -= 1;
      end
    end
    res.blocks = (taken_blocks > 255) ? 8'hFF : BLK_OUT_W'(taken_blocks);
    res.bytes  = (taken_bytes > 65535) ? 16'hFFFF : BYTE_OUT_W'(taken_bytes);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // driver: offers queued items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_results.push_back(apply_pool_op(offered_op));
      if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        offered_op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= offered_op.func;
        in_tdata  <= {{IN_PAD_W{1'b0}}, offered_op.blk_idx, offered_op.req_bytes};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, requested once by the stimulus
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_left <= 400;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor: random backpressure, field by field compare
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: %h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[STATUS_W-1:0] !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_tdata[STATUS_W-1:0], want.status));
          if (out_tdata[GRANT_LO +: GRANT_W] !== want.grant)
            report_mismatch($sformatf("granted_block %0d, expected %0d",
                                      out_tdata[GRANT_LO +: GRANT_W], want.grant));
          if (out_tdata[BLK_LO +: BLK_OUT_W] !== want.blocks)
            report_mismatch($sformatf("blocks_in_use %0d, expected %0d",
                                      out_tdata[BLK_LO +: BLK_OUT_W], want.blocks));
          if (out_tdata[BYTE_LO +: BYTE_OUT_W] !== want.bytes)
            report_mismatch($sformatf("bytes_in_use %0d, expected %0d",
                                      out_tdata[BYTE_LO +: BYTE_OUT_W], want.bytes));
        end
      end
    end
  end

  task automatic push_op(input logic [FUNC_W-1:0] f, input int nbytes, input int idx);
    pool_op_t op;
    op.func      = f;
    op.req_bytes = SIZE_W'(nbytes);
    op.blk_idx   = IN_IDX_W'(idx);
    pending_ops.push_back(op);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  task automatic write_block_bytes(input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    blk_bytes_cfg = val;
  endtask

  // a block currently held, found from a random start; random if none
  function automatic int pick_taken_block();
    int start;
    start = $urandom_range(NUM_BLK - 1);
    for (int k = 0; k < NUM_BLK; k++)
      if (block_taken[(start + k) % NUM_BLK]) return (start + k) % NUM_BLK;
    return $urandom_range(NUM_BLK - 1);
  endfunction

  // one setting of block_bytes, then a stream of mixed operations
  task automatic run_phase(input int cfg_val, input int count, input int alloc_pct);
    int limit;
    int pick;
    int nbytes;
    wait_drained();
    write_block_bytes(CFG_W'(cfg_val));
    limit = (cfg_val > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : cfg_val;
    for (int n = 0; n < count; n++) begin
      while (pending_ops.size() >= 2) @(negedge clk);
      // idle schedule: sender light/receiver heavy, then swapped, then none
      if (random_count < 670) begin
        tx_idle_pct = 29;
        rx_idle_pct = 56;
      end else if (random_count < 1340) begin
        tx_idle_pct = 56;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (random_count == 400) stall_req = 1'b1;
      if ($urandom_range(99) < alloc_pct) begin
        pick = $urandom_range(99);
        if (pick < 60)      nbytes = $urandom_range(limit, 0);
        else if (pick < 68) nbytes = limit;
        else if (pick < 82) nbytes = $urandom_range(1023, limit + 1);
        else                nbytes = $urandom_range(1023, 0);
        push_op(FUNC_ALLOC, nbytes, $urandom_range(NUM_BLK - 1));
      end else begin
        push_op(FUNC_FREE, $urandom_range(1023, 0),
                ($urandom_range(99) < 80) ? pick_taken_block()
                                          : $urandom_range(NUM_BLK - 1));
      end
      random_count++;
    end
  endtask

  // stimulus and end of run
  initial begin
    reset_pool_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: size extremes, LIFO reuse, double free, ignored fields
    push_op(FUNC_ALLOC, 0, 0);
    push_op(FUNC_ALLOC, 256, 127);
    push_op(FUNC_ALLOC, 257, 0);
    push_op(FUNC_ALLOC, 512, 0);
    push_op(FUNC_ALLOC, 1023, 127);
    push_op(FUNC_FREE, 0, 127);
    push_op(FUNC_FREE, 1023, 1);
    push_op(FUNC_ALLOC, 1, 0);
    push_op(FUNC_ALLOC, 255, 0);
    push_op(FUNC_FREE, 0, 0);
    push_op(FUNC_FREE, 0, 0);
    push_op(FUNC_FREE, 0, 2);
    push_op(FUNC_FREE, 0, 1);
    push_op(FUNC_ALLOC, 7, 0);
    push_op(FUNC_ALLOC, 8, 0);
    push_op(FUNC_ALLOC, 9, 0);
    push_op(FUNC_ALLOC, 10, 0);
    push_op(FUNC_FREE, 512, 64);
    push_op(FUNC_FREE, 0, 3);
    push_op(FUNC_ALLOC, 128, 85);

    // random phases; the alloc-heavy ones fill the pool completely
    run_phase(256, 300, 60);
    run_phase(1, 150, 70);
    run_phase(0, 100, 60);
    run_phase(511, 300, 90);
    run_phase(256, 250, 30);
    run_phase(200, 300, 55);
    run_phase(64, 300, 75);
    run_phase($urandom_range(511, 1), 300, 50);

    wait_drained();
    repeat (4) @(posedge clk);
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("expected result never arrived");
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
